/* hdl/escaped_frame_decoder_crc8_core_assert.svh */
// Assertion macros shared by the frame decoder RTL.
`ifndef ESCAPED_FRAME_DECODER_CRC8_CORE_ASSERT_SVH
`define ESCAPED_FRAME_DECODER_CRC8_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define EFD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define EFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/efd_pkg.sv */
// Shared constants, register codes and the CRC-8 byte update of the frame decoder.
package efd_pkg;

	localparam int DEF_MAX_PAYLOAD = 32;

	localparam logic [7:0] HDR_BYTE = 8'hAA;
	localparam logic [7:0] FTR_BYTE = 8'h55;
	localparam logic [7:0] ESC_BYTE = 8'hDB;
	localparam logic [7:0] ESC_XOR  = 8'h20;
	localparam int         MIN_HELD = 2;

	localparam int CFG_W   = 8;
	localparam int CFG_A_W = 2;

	localparam logic [5:0] RST_MAX_PAYLOAD = 6'd32;
	localparam logic [7:0] RST_CRC_POLY    = 8'h07;
	localparam logic [7:0] RST_CRC_INIT    = 8'h00;

	typedef enum logic [CFG_A_W-1:0] {
		REG_MAX_PAYLOAD = 2'd0,
		REG_CRC_POLY    = 2'd1,
		REG_CRC_INIT    = 2'd2
	} reg_idx_t;

	// MSB-first CRC-8 over one byte, no final xor.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

/* hdl/efd_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module efd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/efd_cmdq.sv */
// Two-entry queue of finished-frame commands between front and back.
module efd_cmdq #(
	parameter int W = 7
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] dout
);

	logic [W-1:0] ent_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign valid = (cnt_q != 2'd0);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

endmodule

/* hdl/efd_front.sv */
// Front end: byte intake, header/escape/footer parsing and frame store writes.
module efd_front #(
	parameter int MAX_PAYLOAD = efd_pkg::DEF_MAX_PAYLOAD,
	localparam int IDX_W = $clog2(MAX_PAYLOAD + 1),
	localparam int FILL_W = $clog2(MAX_PAYLOAD + 2)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [7:0]       in_byte,
	output logic             full,
	input  logic [5:0]       max_payload,
	output logic             wr_en,
	output logic [IDX_W:0]   wr_addr,
	output logic [7:0]       wr_data,
	output logic             cmd_push,
	output logic             cmd_bank,
	output logic [IDX_W-1:0] cmd_plen,
	input  logic             frame_done
);

	`include "escaped_frame_decoder_crc8_core_assert.svh"

	typedef enum logic [2:0] {
		PH_SYNC    = 3'b001,
		PH_COLLECT = 3'b010,
		PH_ESCAPED = 3'b100
	} phase_t;

	localparam logic [5:0] MAX_CLIP = 6'(MAX_PAYLOAD);

	phase_t            phase_q, phase_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic              bank_q;
	logic [1:0]        out_cnt_q;

	logic              acc;
	logic [5:0]        mp_clip;
	logic [6:0]        cap7, fill7, inc7;
	logic [FILL_W-1:0] fill_inc, plen_w;
	logic [7:0]        unesc;
	logic              esc_ok;

	assign full    = (out_cnt_q == 2'd2);
	assign acc     = push && !full;
	assign mp_clip = (max_payload > MAX_CLIP) ? MAX_CLIP : max_payload;
	assign cap7    = {1'b0, mp_clip} + 7'd1;
	assign fill7   = 7'(fill_q);
	assign inc7    = fill7 + 7'd1;
	// count wraps at 64 like a 6-bit counter
	assign fill_inc = FILL_W'(inc7[5:0]);
	assign unesc   = in_byte ^ efd_pkg::ESC_XOR;
	assign esc_ok  = (unesc == efd_pkg::HDR_BYTE) || (unesc == efd_pkg::FTR_BYTE) ||
		(unesc == efd_pkg::ESC_BYTE);

	assign wr_addr  = {bank_q, fill_q[IDX_W-1:0]};
	assign plen_w   = fill_q - FILL_W'(1);
	assign cmd_plen = plen_w[IDX_W-1:0];
	assign cmd_bank = bank_q;

	always_comb begin
		phase_d  = phase_q;
		fill_d   = fill_q;
		wr_en    = 1'b0;
		wr_data  = in_byte;
		cmd_push = 1'b0;
		if (acc) begin
			unique case (phase_q)
				PH_SYNC: begin
					if (in_byte == efd_pkg::HDR_BYTE) begin
						fill_d  = '0;
						phase_d = PH_COLLECT;
					end
				end
				PH_COLLECT: begin
					priority if (in_byte == efd_pkg::FTR_BYTE) begin
						// CRC verdict is left to the back end
						cmd_push = (fill7 >= 7'(efd_pkg::MIN_HELD));
						fill_d   = '0;
						phase_d  = PH_SYNC;
					end else if (in_byte == efd_pkg::ESC_BYTE) begin
						phase_d = PH_ESCAPED;
					end else if (in_byte == efd_pkg::HDR_BYTE || fill7 == cap7) begin
						fill_d  = '0;
						phase_d = (in_byte == efd_pkg::HDR_BYTE) ? PH_COLLECT : PH_SYNC;
					end else if (fill7 < cap7) begin
						wr_en  = 1'b1;
						fill_d = fill_inc;
					end else begin
						fill_d  = '0;
						phase_d = PH_SYNC;
					end
				end
				PH_ESCAPED: begin
					priority if (!esc_ok) begin
						// bad escape: byte is rescanned as if in sync
						fill_d  = '0;
						phase_d = (in_byte == efd_pkg::HDR_BYTE) ? PH_COLLECT : PH_SYNC;
					end else if (fill7 < cap7) begin
						wr_en   = 1'b1;
						wr_data = unesc;
						fill_d  = fill_inc;
						phase_d = PH_COLLECT;
					end else begin
						fill_d  = '0;
						phase_d = PH_SYNC;
					end
				end
				default: begin
					fill_d  = '0;
					phase_d = PH_SYNC;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SYNC;
			fill_q    <= '0;
			bank_q    <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			phase_q   <= phase_d;
			fill_q    <= fill_d;
			if (cmd_push) begin
				bank_q <= ~bank_q;
			end
			out_cnt_q <= out_cnt_q + {1'b0, cmd_push} - {1'b0, frame_done};
		end
	end

	`EFD_ASSERT_IMPL(a_out_cnt_range, 1'b1, out_cnt_q != 2'd3, "frame handoff count overran")
	`EFD_ASSERT_IMPL(a_done_owned, frame_done, out_cnt_q != 2'd0, "frame done with none outstanding")
	`EFD_ASSERT_IMPL(a_wr_in_store, wr_en, fill7 <= 7'(MAX_PAYLOAD), "store write past capacity")

endmodule

/* hdl/efd_back.sv */
// Back end: CRC check over a held frame, then payload readout into the result queue.
module efd_back #(
	parameter int MAX_PAYLOAD = efd_pkg::DEF_MAX_PAYLOAD,
	localparam int IDX_W = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       crc_poly,
	input  logic [7:0]       crc_init,
	input  logic             cmd_valid,
	input  logic             cmd_bank,
	input  logic [IDX_W-1:0] cmd_plen,
	output logic             cmd_pop,
	output logic             rd_en,
	output logic [IDX_W:0]   rd_addr,
	input  logic [7:0]       rd_data,
	output logic             frame_done,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       payload_byte,
	output logic [4:0]       byte_index,
	output logic             last
);

	`include "escaped_frame_decoder_crc8_core_assert.svh"

	typedef enum logic [2:0] {
		BK_IDLE  = 3'b001,
		BK_CHECK = 3'b010,
		BK_EMIT  = 3'b100
	} bk_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic [4:0] idx;
		logic       last;
	} out_t;

	bk_state_t        state_q, state_d;
	logic             bank_q, bank_d;
	logic [IDX_W-1:0] plen_q, plen_d;
	logic [IDX_W:0]   rd_idx_q, rd_idx_d;
	logic [7:0]       crc_q, crc_d;
	logic             rd_v_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	out_t             ent_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       occ_q;
	logic             fifo_push, fifo_pop;
	out_t             fifo_in;

	logic [IDX_W:0]   plen_ext;
	logic [IDX_W-1:0] plen_m1;

	assign plen_ext = {1'b0, plen_q};
	assign plen_m1  = plen_q - IDX_W'(1);
	assign rd_addr  = {bank_q, rd_idx_q[IDX_W-1:0]};

	assign fifo_in.data = rd_data;
	assign fifo_in.idx  = 5'(rd_idx_s1);
	assign fifo_in.last = (rd_idx_s1 == plen_m1);

	always_comb begin
		state_d    = state_q;
		bank_d     = bank_q;
		plen_d     = plen_q;
		crc_d      = crc_q;
		cmd_pop    = 1'b0;
		frame_done = 1'b0;
		fifo_push  = 1'b0;
		rd_en      = 1'b0;
		unique case (state_q)
			BK_CHECK: rd_en = (rd_idx_q <= plen_ext);
			// keep in-flight reads within the two free result slots
			BK_EMIT:  rd_en = (rd_idx_q < plen_ext) && ((occ_q + {1'b0, rd_v_s1}) < 2'd2);
			default:  rd_en = 1'b0;
		endcase
		rd_idx_d = rd_idx_q + {{IDX_W{1'b0}}, rd_en};
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop  = 1'b1;
					bank_d   = cmd_bank;
					plen_d   = cmd_plen;
					crc_d    = crc_init;
					rd_idx_d = '0;
					state_d  = BK_CHECK;
				end
			end
			BK_CHECK: begin
				if (rd_v_s1) begin
					priority if (rd_idx_s1 != plen_q) begin
						crc_d = efd_pkg::crc8_byte(crc_q, rd_data, crc_poly);
					end else if (crc_q == rd_data) begin
						rd_idx_d = '0;
						state_d  = BK_EMIT;
					end else begin
						frame_done = 1'b1;
						state_d    = BK_IDLE;
					end
				end
			end
			BK_EMIT: begin
				if (rd_v_s1) begin
					fifo_push = 1'b1;
					if (fifo_in.last) begin
						frame_done = 1'b1;
						state_d    = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign empty        = (occ_q == 2'd0);
	assign fifo_pop     = pop && !empty;
	assign payload_byte = ent_q[rp_q].data;
	assign byte_index   = ent_q[rp_q].idx;
	assign last         = ent_q[rp_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			rd_v_s1  <= 1'b0;
			rd_idx_q <= '0;
			wp_q     <= 1'b0;
			rp_q     <= 1'b0;
			occ_q    <= 2'd0;
		end else begin
			state_q  <= state_d;
			rd_v_s1  <= rd_en;
			rd_idx_q <= rd_idx_d;
			if (fifo_push) begin
				wp_q <= ~wp_q;
			end
			if (fifo_pop) begin
				rp_q <= ~rp_q;
			end
			occ_q <= occ_q + {1'b0, fifo_push} - {1'b0, fifo_pop};
		end
	end

	always_ff @(posedge clk) begin
		bank_q    <= bank_d;
		plen_q    <= plen_d;
		crc_q     <= crc_d;
		rd_idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (fifo_push) begin
			ent_q[wp_q] <= fifo_in;
		end
	end

	`EFD_ASSERT_IMPL(a_res_room, fifo_push, occ_q != 2'd2, "result queue overflow")
	`EFD_ASSERT_IMPL(a_rd_busy, rd_v_s1, state_q != BK_IDLE, "read data returned while idle")
	`EFD_ASSERT_NEXT(a_done_idle, frame_done, state_q == BK_IDLE, "frame done without going idle")

endmodule

/* hdl/escaped_frame_decoder_crc8_core.sv */
// Top level of the byte-stuffed frame decoder with CRC-8 check.
//
//   channel   | ports                                   | transaction when
//   ----------+-----------------------------------------+------------------------
//   input     | push, full, in_byte                     | push && !full
//   result    | empty, pop, payload_byte, byte_index,   | pop && !empty
//             | last                                    |
//   config    | cfg_we, cfg_addr, cfg_data              | cfg_we
//
// Flow: one raw byte per cycle into the front; full is high while both store
// banks are owned by the back. Per frame the back pops a command, reads the stored
// bytes for the CRC check, then rereads the payload while result slots are free.
// Reset: arst_n clears all control state; the frame store is not cleared, only
// bytes written in the current frame are read back.
// Stalls: a held result stalls only the back end; full rises once two frames wait.
module escaped_frame_decoder_crc8_core #(
	parameter int MAX_PAYLOAD = efd_pkg::DEF_MAX_PAYLOAD
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// raw link bytes
	input  logic                        push,
	input  logic [7:0]                  in_byte,
	output logic                        full,
	// decoded payload
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  payload_byte,
	output logic [4:0]                  byte_index,
	output logic                        last,
	// register writes
	input  logic                        cfg_we,
	input  logic [efd_pkg::CFG_A_W-1:0] cfg_addr,
	input  logic [efd_pkg::CFG_W-1:0]   cfg_data
);

	localparam int IDX_W     = $clog2(MAX_PAYLOAD + 1);
	// two banks: front fills one while the back works the other
	localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

	// config registers
	logic [5:0] max_payload_q;
	logic [7:0] crc_poly_q;
	logic [7:0] crc_init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= efd_pkg::RST_MAX_PAYLOAD;
			crc_poly_q    <= efd_pkg::RST_CRC_POLY;
			crc_init_q    <= efd_pkg::RST_CRC_INIT;
		end else if (cfg_we) begin
			unique case (efd_pkg::reg_idx_t'(cfg_addr))
				efd_pkg::REG_MAX_PAYLOAD: max_payload_q <= cfg_data[5:0];
				efd_pkg::REG_CRC_POLY:    crc_poly_q    <= cfg_data;
				efd_pkg::REG_CRC_INIT:    crc_init_q    <= cfg_data;
				default: ; // unmapped index, write ignored
			endcase
		end
	end

	// store write side (front) and read side (back)
	logic             wr_en;
	logic [IDX_W:0]   wr_addr;
	logic [7:0]       wr_data;
	logic             rd_en;
	logic [IDX_W:0]   rd_addr;
	logic [7:0]       rd_data;

	// finished-frame commands: bank and payload length
	logic             cmd_push, cmd_bank, cmd_pop, cmd_valid;
	logic [IDX_W-1:0] cmd_plen;
	logic [IDX_W:0]   cmd_out;
	logic             frame_done;

	efd_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.in_byte    (in_byte),
		.full       (full),
		.max_payload(max_payload_q),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.cmd_push   (cmd_push),
		.cmd_bank   (cmd_bank),
		.cmd_plen   (cmd_plen),
		.frame_done (frame_done)
	);

	efd_cmdq #(
		.W(IDX_W + 1)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.din   ({cmd_bank, cmd_plen}),
		.pop   (cmd_pop),
		.valid (cmd_valid),
		.dout  (cmd_out)
	);

	efd_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	efd_back #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.crc_poly    (crc_poly_q),
		.crc_init    (crc_init_q),
		.cmd_valid   (cmd_valid),
		.cmd_bank    (cmd_out[IDX_W]),
		.cmd_plen    (cmd_out[IDX_W-1:0]),
		.cmd_pop     (cmd_pop),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.frame_done  (frame_done),
		.empty       (empty),
		.pop         (pop),
		.payload_byte(payload_byte),
		.byte_index  (byte_index),
		.last        (last)
	);

endmodule
